[rtl/assert_macros.svh]
// assertion macros used by edf_task_scheduler_top
// no dependencies; pulled in with an include where checks are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under synchronous reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication under synchronous reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/edf_pkg.sv]
// types and constants of the edf task scheduler
// no dependencies; used by edf_task_scheduler_top
package edf_pkg;

   // default sizing
   localparam int MAX_TASKS_DEF = 16;
   localparam int TIME_BITS_DEF = 32;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM      = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TASKS_IN_USE = 1'd1;
   localparam logic [15:0] QUANTUM_RESET = 16'd1;

   // item operations
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // request beat
   typedef struct packed {
      logic        op;
      logic [3:0]  task_slot;
      logic [15:0] task_period;
      logic [15:0] task_budget;
   } req_type;

   // response beat
   typedef struct packed {
      logic        ran_valid;
      logic [3:0]  ran_task;
      logic        job_done;
      logic [15:0] job_number;
      logic [31:0] job_start;
      logic [31:0] job_end;
      logic        deadline_missed;
      logic        halted;
   } rsp_type;

endpackage

[rtl/edf_task_scheduler_top.sv]
// earliest-deadline-first scheduler for periodic tasks, top level
// depends on edf_pkg and assert_macros.svh
//
// usage:
//   req channel (valid/ready) carries one beat per item: a load writes one task
//   entry (period, budget), a tick advances time by the quantum and charges the
//   released job with the earliest deadline (ties round-robin).
//   rsp channel (valid/ready) returns exactly one beat per request beat.
//   csr port: csr_we with csr_index 0 = quantum, 1 = tasks_in_use; the user must
//   write it only while the block is idle; the block does not enforce this.
// sequence:
//   a load goes from accept straight to the output stage; a tick passes the
//   scan, advance and commit states, the scan reading each task entry in use,
//   one per cycle, from the task memory; a tick while halted goes straight to
//   the output stage. One item is processed at a time.
// reset: time, round-robin pointer and halt flag clear, quantum = 1,
//   tasks_in_use = 0; task entries hold nothing until loaded.
// stall: the response sits in an output register; the next request beat is
//   taken while it waits, and processing holds before the output stage.
`include "assert_macros.svh"

module edf_task_scheduler_top #(
   parameter int MAX_TASKS = edf_pkg::MAX_TASKS_DEF,
   parameter int TIME_BITS = edf_pkg::TIME_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  edf_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output edf_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [edf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [edf_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IDX_W = $clog2(MAX_TASKS);
   localparam int CNT_W = $clog2(MAX_TASKS + 1);
   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TASKS - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_ADV,
      S_COMMIT,
      S_OUT
   } state_type;

   // one task entry of the memory
   typedef struct packed {
      logic [15:0]          period;
      logic [15:0]          budget;
      logic [TIME_BITS-1:0] rel_t;
      logic [TIME_BITS-1:0] dl_t;
      logic [15:0]          served;
      logic [15:0]          jobs;
      logic [TIME_BITS-1:0] start_t;
   } entry_type;

   // control and payload registers
   state_type            state_ff;
   logic [15:0]          quantum_ff;
   logic [4:0]           tasks_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic [IDX_W-1:0]     tie_ptr_ff;
   logic                 stopped_ff;
   logic                 found_ff;
   logic [CNT_W-1:0]     rd_cnt_ff;
   logic                 chk_valid_ff;
   logic [IDX_W-1:0]     chk_idx_ff;
   logic [IDX_W-1:0]     best_idx_ff;
   logic [IDX_W-1:0]     best_key_ff;
   entry_type            best_ff;
   logic [TIME_BITS-1:0] rel_next_ff;
   logic [TIME_BITS-1:0] dl_next_ff;
   edf_pkg::rsp_type     res_ff;
   logic                 rsp_valid_ff;
   edf_pkg::rsp_type     rsp_data_ff;

   // task memory
   entry_type            mem [MAX_TASKS];
   entry_type            mem_q;
   logic                 mem_we;
   logic [IDX_W-1:0]     mem_wa;
   entry_type            mem_wd;
   logic [IDX_W-1:0]     rd_addr;

   // combinational helpers
   logic                 req_fire;
   logic                 slot_ok;
   entry_type            load_rec;
   entry_type            wb_rec;
   logic [CNT_W-1:0]     n_tasks;
   logic [IDX_W-1:0]     chk_key;
   logic                 released;
   logic                 better;
   logic [TIME_BITS:0]   now_sum;
   logic [TIME_BITS-1:0] now_adv;
   logic [16:0]          served_sum;
   logic [15:0]          served_adv;
   logic [TIME_BITS-1:0] start_adv;
   logic [TIME_BITS:0]   rel_sum;
   logic [TIME_BITS:0]   dl_sum;
   logic [IDX_W-1:0]     tie_next;
   logic                 miss;
   logic                 done;
   edf_pkg::rsp_type     res_commit;
   edf_pkg::rsp_type     res_load;
   edf_pkg::rsp_type     res_halt;

   // handshakes
   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff <= edf_pkg::QUANTUM_RESET;
         tasks_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            edf_pkg::CSR_QUANTUM:      quantum_ff <= csr_wdata;
            edf_pkg::CSR_TASKS_IN_USE: tasks_ff   <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // fresh entry written by a load beat
   always_comb begin
      slot_ok          = 32'(req_data.task_slot) < MAX_TASKS;
      load_rec.period  = req_data.task_period;
      load_rec.budget  = req_data.task_budget;
      load_rec.rel_t   = '0;
      load_rec.dl_t    = TIME_BITS'(req_data.task_period);
      load_rec.served  = '0;
      load_rec.jobs    = 16'd1;
      load_rec.start_t = '0;
   end

   // scan: entry count, tie key and candidate test
   always_comb begin
      n_tasks  = CNT_W'((32'(tasks_ff) > MAX_TASKS) ? MAX_TASKS : 32'(tasks_ff));
      rd_addr  = rd_cnt_ff[IDX_W-1:0];
      chk_key  = (chk_idx_ff >= tie_ptr_ff) ? (chk_idx_ff - tie_ptr_ff)
               : IDX_W'(32'(chk_idx_ff) + MAX_TASKS - 32'(tie_ptr_ff));
      released = (mem_q.rel_t <= now_ff);
      better   = !found_ff || (mem_q.dl_t < best_ff.dl_t)
               || ((mem_q.dl_t == best_ff.dl_t) && (chk_key < best_key_ff));
   end

   // charge: time advance, served amount, next release and deadline
   always_comb begin
      now_sum    = {1'b0, now_ff} + (TIME_BITS+1)'(quantum_ff);
      now_adv    = now_sum[TIME_BITS] ? TIME_MAX : now_sum[TIME_BITS-1:0];
      served_sum = {1'b0, best_ff.served} + {1'b0, quantum_ff};
      served_adv = served_sum[16] ? 16'hFFFF : served_sum[15:0];
      start_adv  = (best_ff.served == '0) ? now_ff : best_ff.start_t;
      rel_sum    = {1'b0, best_ff.rel_t} + (TIME_BITS+1)'(best_ff.period);
      dl_sum     = {1'b0, best_ff.dl_t} + (TIME_BITS+1)'(best_ff.period);
      tie_next   = (best_idx_ff == LAST_IDX) ? '0 : best_idx_ff + 1'b1;
   end

   // commit: miss and completion, write-back entry and response
   always_comb begin
      miss   = (now_ff > best_ff.dl_t);
      done   = !miss && (best_ff.served >= best_ff.budget);
      wb_rec = best_ff;
      if (done) begin
         wb_rec.jobs    = (best_ff.jobs == 16'hFFFF) ? best_ff.jobs : best_ff.jobs + 16'd1;
         wb_rec.rel_t   = rel_next_ff;
         wb_rec.dl_t    = dl_next_ff;
         wb_rec.served  = '0;
         wb_rec.start_t = rel_next_ff;
      end
      res_commit                 = '0;
      res_commit.job_end         = 32'(now_ff);
      res_commit.halted          = stopped_ff || (found_ff && miss);
      if (found_ff) begin
         res_commit.ran_valid       = 1'b1;
         res_commit.ran_task        = 4'(best_idx_ff);
         res_commit.job_done        = done;
         res_commit.job_number      = best_ff.jobs;
         res_commit.job_start       = 32'(best_ff.start_t);
         res_commit.deadline_missed = miss;
      end
      res_load          = '0;
      res_load.halted   = stopped_ff;
      res_halt          = '0;
      res_halt.job_end  = 32'(now_ff);
      res_halt.halted   = 1'b1;
   end

   // memory write port: loads at accept, write-back at commit
   always_comb begin
      mem_we = (req_fire && (req_data.op == edf_pkg::OP_LOAD) && slot_ok)
             || ((state_ff == S_COMMIT) && found_ff);
      mem_wa = (state_ff == S_COMMIT) ? best_idx_ff : IDX_W'(req_data.task_slot);
      mem_wd = (state_ff == S_COMMIT) ? wb_rec : load_rec;
   end

   // task memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_q <= mem[rd_addr];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         now_ff       <= '0;
         tie_ptr_ff   <= '0;
         stopped_ff   <= 1'b0;
         found_ff     <= 1'b0;
         rd_cnt_ff    <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // output beat taken while no new one is loaded
         if (rsp_valid_ff && rsp_ready && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  if (req_data.op == edf_pkg::OP_LOAD) begin
                     res_ff   <= res_load;
                     state_ff <= S_OUT;
                  end else if (stopped_ff) begin
                     res_ff   <= res_halt;
                     state_ff <= S_OUT;
                  end else begin
                     found_ff     <= 1'b0;
                     rd_cnt_ff    <= '0;
                     chk_valid_ff <= 1'b0;
                     state_ff     <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               // judge the entry read last cycle
               if (chk_valid_ff && released && better) begin
                  found_ff    <= 1'b1;
                  best_idx_ff <= chk_idx_ff;
                  best_key_ff <= chk_key;
                  best_ff     <= mem_q;
               end
               // issue the next read
               chk_idx_ff <= rd_addr;
               if (rd_cnt_ff < n_tasks) begin
                  rd_cnt_ff    <= rd_cnt_ff + 1'b1;
                  chk_valid_ff <= 1'b1;
               end else begin
                  chk_valid_ff <= 1'b0;
               end
               if (rd_cnt_ff == n_tasks) begin
                  state_ff <= S_ADV;
               end
            end
            S_ADV: begin
               now_ff <= now_adv;
               if (now_sum[TIME_BITS]) begin
                  stopped_ff <= 1'b1;
               end
               if (found_ff) begin
                  best_ff.served  <= served_adv;
                  best_ff.start_t <= start_adv;
                  tie_ptr_ff      <= tie_next;
               end
               rel_next_ff <= rel_sum[TIME_BITS] ? TIME_MAX : rel_sum[TIME_BITS-1:0];
               dl_next_ff  <= dl_sum[TIME_BITS] ? TIME_MAX : dl_sum[TIME_BITS-1:0];
               state_ff    <= S_COMMIT;
            end
            S_COMMIT: begin
               res_ff <= res_commit;
               if (found_ff && miss) begin
                  stopped_ff <= 1'b1;
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_data_ff  <= res_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // checks
   `ASSERT_NEXT(a_halt_sticky, clock, reset, stopped_ff, stopped_ff, "halt flag cleared without reset")
   `ASSERT_IMPL(a_mem_write_src, clock, reset, mem_we, ((state_ff == S_COMMIT) && found_ff) || req_fire, "task memory written outside load or commit")
   `ASSERT_IMPL(a_miss_halts, clock, reset, rsp_valid && rsp_data.deadline_missed, rsp_data.halted && rsp_data.ran_valid, "deadline miss without halt")
   `ASSERT_IMPL(a_done_ran, clock, reset, rsp_valid && rsp_data.job_done, rsp_data.ran_valid && !rsp_data.deadline_missed, "completion without a charged job")

endmodule
